### sv/alkd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alkd_pkg: shared types and constants of the lattice kick/drift engine
// Operation codes, command and status bundles, register indexes and the
// 32-bit saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package alkd_pkg;

	localparam int COMP_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int SQ_CNT_W   = 5;
	localparam int SQRT_STEPS = 32;

	localparam logic signed [63:0] S32_MAX_64 = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN_64 = -64'sd2147483648;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_KICK  = 2'd1,
		MODE_DRIFT = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INV_MASS  = 3'd0,
		CFG_SPRING_K  = 3'd1,
		CFG_QUAD      = 3'd2,
		CFG_CUBIC     = 3'd3,
		CFG_TIME_STEP = 3'd4
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_WRITE,
		OP_RD_ISSUE,
		OP_RD_TAKE,
		OP_K_RA,
		OP_K_RB,
		OP_K_DIFF,
		OP_K_SQ,
		OP_K_ACC,
		OP_SQ_INIT,
		OP_SQ_STEP,
		OP_C_MUL,
		OP_C_SUM,
		OP_U_M1,
		OP_U_M2,
		OP_U_M3,
		OP_U_M4,
		OP_D_RD,
		OP_D_M1,
		OP_D_M2,
		OP_D_WR
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [COMP_W-1:0] comp;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  addr_ok;
		logic  kick_ok;
		logic  entry_last;
	} dp_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > S32_MAX_64) begin
			return 32'sh7fffffff;
		end else if (x < S32_MIN_64) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic ovf32(input logic signed [63:0] x);
		return (x > S32_MAX_64) || (x < S32_MIN_64);
	endfunction

endpackage
`default_nettype wire

### sv/alkd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alkd_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered and held while
// no read is issued.
// ----------------------------------------------------------------------------
module alkd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/alkd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alkd_ctrl: sequencing state machine
// Steps the datapath through write, read, kick and drift sequences and
// raises the done strobe when an item finishes.
// ----------------------------------------------------------------------------
module alkd_ctrl #(
	parameter int DIMS = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire alkd_pkg::dp_stat_t stat,
	output logic                   busy,
	output logic                   load,
	output alkd_pkg::dp_cmd_t      cmd,
	output logic                   done
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISP,
		ST_WRITE,
		ST_RD_ISSUE,
		ST_RD_TAKE,
		ST_K_RA,
		ST_K_RB,
		ST_K_DIFF,
		ST_K_SQ,
		ST_K_ACC,
		ST_SQ_INIT,
		ST_SQ_STEP,
		ST_C_MUL,
		ST_C_SUM,
		ST_U_M1,
		ST_U_M2,
		ST_U_M3,
		ST_U_M4,
		ST_D_RD,
		ST_D_M1,
		ST_D_M2,
		ST_D_WR
	} state_t;

	localparam logic [alkd_pkg::COMP_W-1:0] COMP_LAST = alkd_pkg::COMP_W'(DIMS - 1);
	localparam logic [alkd_pkg::SQ_CNT_W-1:0] CNT_LAST =
		alkd_pkg::SQ_CNT_W'(alkd_pkg::SQRT_STEPS - 1);

	state_t                          state_q, state_d;
	logic [alkd_pkg::COMP_W-1:0]     comp_q, comp_d;
	logic [alkd_pkg::SQ_CNT_W-1:0]   cnt_q, cnt_d;
	alkd_pkg::dp_op_t                op_q, op_d;
	logic                            done_q, done_d;

	assign busy = (state_q != ST_IDLE);
	assign load = start && (state_q == ST_IDLE);
	assign done = done_q;
	assign cmd  = '{op: op_q, comp: comp_q};

	always_comb begin
		state_d = state_q;
		comp_d  = comp_q;
		cnt_d   = cnt_q;
		done_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				unique case (stat.mode)
					alkd_pkg::MODE_WRITE: state_d = ST_WRITE;
					alkd_pkg::MODE_READ:  state_d = ST_RD_ISSUE;
					alkd_pkg::MODE_DRIFT: state_d = ST_D_RD;
					alkd_pkg::MODE_KICK: begin
						comp_d = '0;
						if (stat.kick_ok) begin
							state_d = ST_K_RA;
						end else begin
							state_d = ST_IDLE;
							done_d  = 1'b1;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_WRITE, ST_RD_TAKE: begin
				state_d = ST_IDLE;
				done_d  = 1'b1;
			end
			ST_RD_ISSUE: state_d = ST_RD_TAKE;
			ST_K_RA:     state_d = ST_K_RB;
			ST_K_RB:     state_d = ST_K_DIFF;
			ST_K_DIFF:   state_d = ST_K_SQ;
			ST_K_SQ:     state_d = ST_K_ACC;
			ST_K_ACC: begin
				if (comp_q == COMP_LAST) begin
					comp_d  = '0;
					state_d = ST_SQ_INIT;
				end else begin
					comp_d  = comp_q + 1'b1;
					state_d = ST_K_RA;
				end
			end
			ST_SQ_INIT: begin
				cnt_d   = '0;
				state_d = ST_SQ_STEP;
			end
			ST_SQ_STEP: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_C_MUL;
				end
			end
			ST_C_MUL: state_d = ST_C_SUM;
			ST_C_SUM: state_d = ST_U_M1;
			ST_U_M1:  state_d = ST_U_M2;
			ST_U_M2:  state_d = ST_U_M3;
			ST_U_M3:  state_d = ST_U_M4;
			ST_U_M4: begin
				if (comp_q == COMP_LAST) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end else begin
					comp_d  = comp_q + 1'b1;
					state_d = ST_U_M1;
				end
			end
			ST_D_RD: state_d = ST_D_M1;
			ST_D_M1: state_d = ST_D_M2;
			ST_D_M2: state_d = ST_D_WR;
			ST_D_WR: begin
				if (stat.entry_last) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end else begin
					state_d = ST_D_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_d)
			ST_WRITE:    op_d = alkd_pkg::OP_WRITE;
			ST_RD_ISSUE: op_d = alkd_pkg::OP_RD_ISSUE;
			ST_RD_TAKE:  op_d = alkd_pkg::OP_RD_TAKE;
			ST_K_RA:     op_d = alkd_pkg::OP_K_RA;
			ST_K_RB:     op_d = alkd_pkg::OP_K_RB;
			ST_K_DIFF:   op_d = alkd_pkg::OP_K_DIFF;
			ST_K_SQ:     op_d = alkd_pkg::OP_K_SQ;
			ST_K_ACC:    op_d = alkd_pkg::OP_K_ACC;
			ST_SQ_INIT:  op_d = alkd_pkg::OP_SQ_INIT;
			ST_SQ_STEP:  op_d = alkd_pkg::OP_SQ_STEP;
			ST_C_MUL:    op_d = alkd_pkg::OP_C_MUL;
			ST_C_SUM:    op_d = alkd_pkg::OP_C_SUM;
			ST_U_M1:     op_d = alkd_pkg::OP_U_M1;
			ST_U_M2:     op_d = alkd_pkg::OP_U_M2;
			ST_U_M3:     op_d = alkd_pkg::OP_U_M3;
			ST_U_M4:     op_d = alkd_pkg::OP_U_M4;
			ST_D_RD:     op_d = alkd_pkg::OP_D_RD;
			ST_D_M1:     op_d = alkd_pkg::OP_D_M1;
			ST_D_M2:     op_d = alkd_pkg::OP_D_M2;
			ST_D_WR:     op_d = alkd_pkg::OP_D_WR;
			default:     op_d = alkd_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			comp_q  <= '0;
			cnt_q   <= '0;
			op_q    <= alkd_pkg::OP_NOP;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			comp_q  <= comp_d;
			cnt_q   <= cnt_d;
			op_q    <= op_d;
			done_q  <= done_d;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("done strobe outside idle");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy && !done_q))
		else $error("accepted beat did not start a sequence");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

	a_sqrt_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ_STEP && cnt_q == CNT_LAST) |=> (state_q == ST_C_MUL))
		else $error("root iteration count broken");

endmodule
`default_nettype wire

### sv/alkd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alkd_dp: lattice datapath
// Position and momentum stores, configuration registers, multipliers,
// bit-pair square root unit and saturation logic, driven by commands.
// ----------------------------------------------------------------------------
module alkd_dp #(
	parameter int MAX_PARTICLES = 256,
	parameter int DIMS          = 3
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load,
	input  wire alkd_pkg::dp_cmd_t                 cmd,
	output alkd_pkg::dp_stat_t                     stat,
	input  wire logic [1:0]                        mode,
	input  wire logic [7:0]                        particle_a,
	input  wire logic [7:0]                        particle_b,
	input  wire logic [1:0]                        component,
	input  wire logic signed [31:0]                position_in,
	input  wire logic signed [31:0]                momentum_in,
	input  wire logic                              cfg_we,
	input  wire logic [alkd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [31:0]                       cfg_data,
	output logic signed [31:0]                     position_out,
	output logic signed [31:0]                     momentum_out,
	output logic                                   saturated
);

	localparam int DEPTH = MAX_PARTICLES * DIMS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (DIMS > 1) ? $clog2(DIMS) : 1;

	alkd_pkg::mode_t    mode_q;
	logic [7:0]         a_q, b_q;
	logic [1:0]         comp_q;
	logic signed [31:0] pin_q, min_q;

	logic [30:0]        inv_q, dt_q;
	logic signed [31:0] spring_q, quad_q, cubic_q;

	logic               sat_q;
	logic [AW-1:0]      entry_q;

	logic signed [31:0] qa_q, pa_q, coeff_q;
	logic signed [31:0] d_q [DIMS];
	logic [63:0]        sq_q, s_q, sh_q;
	logic [32:0]        rem_q;
	logic [31:0]        root_q;
	logic signed [63:0] p1_q, p2_q, fprod_q, iprod_q, vprod_q, dprod_q;
	logic signed [31:0] pos_out_q, mom_out_q;

	logic [CW-1:0]      c_idx;
	logic [AW-1:0]      idx_a, idx_b, idx_w;
	logic               addr_ok, kick_ok;

	logic               pos_we, pos_re, mom_we, mom_re;
	logic [AW-1:0]      pos_waddr, pos_raddr, mom_waddr, mom_raddr;
	logic signed [31:0] pos_wdata, mom_wdata, pos_rd, mom_rd;

	logic signed [32:0] diff;
	logic signed [31:0] d_clip;
	logic               d_ovf;
	logic signed [63:0] sq_prod;
	logic [34:0]        rem_sh, trial;
	logic               r2_ovf;
	logic [30:0]        r2;
	logic signed [64:0] p1_full;
	logic signed [63:0] p2_full;
	logic signed [49:0] csum;
	logic signed [63:0] fprod, iprod, vprod, dprod, imp;
	logic signed [31:0] f_sat, v_sat;
	logic signed [63:0] pa_sum, pb_dif, q_sum;

	assign c_idx   = cmd.comp[CW-1:0];
	assign addr_ok = ({24'd0, a_q} < 32'(MAX_PARTICLES)) && ({30'd0, comp_q} < 32'(DIMS));
	assign kick_ok = ({24'd0, a_q} < 32'(MAX_PARTICLES))
		&& ({24'd0, b_q} < 32'(MAX_PARTICLES)) && (a_q != b_q);
	assign idx_a   = AW'(32'(a_q) * DIMS + 32'(cmd.comp));
	assign idx_b   = AW'(32'(b_q) * DIMS + 32'(cmd.comp));
	assign idx_w   = AW'(32'(a_q) * DIMS + 32'(comp_q));

	assign stat = '{mode: mode_q, addr_ok: addr_ok, kick_ok: kick_ok,
		entry_last: (entry_q == AW'(DEPTH - 1))};

	assign diff    = 33'(pos_rd) - 33'(qa_q);
	assign d_ovf   = (diff > 33'sd2147483647) || (diff < -33'sd2147483647);
	assign d_clip  = (diff > 33'sd2147483647) ? 32'sh7fffffff :
		(diff < -33'sd2147483647) ? 32'sh80000001 : diff[31:0];
	assign sq_prod = d_q[c_idx] * d_q[c_idx];

	assign rem_sh  = {rem_q, sh_q[63:62]};
	assign trial   = {1'b0, root_q, 2'b01};

	assign r2_ovf  = |s_q[63:47];
	assign r2      = r2_ovf ? 31'h7fffffff : s_q[46:16];
	assign p1_full = quad_q * $signed({1'b0, root_q});
	assign p2_full = cubic_q * $signed({1'b0, r2});
	assign csum    = 50'(spring_q) + 50'(p1_q >>> 16) + 50'(p2_q >>> 16);

	assign fprod   = coeff_q * d_q[c_idx];
	assign f_sat   = alkd_pkg::sat32(fprod_q >>> 16);
	assign iprod   = $signed({1'b0, dt_q}) * f_sat;
	assign imp     = iprod_q >>> 16;
	assign pa_sum  = 64'(pa_q) + imp;
	assign pb_dif  = 64'(mom_rd) - imp;

	assign vprod   = mom_rd * $signed({1'b0, inv_q});
	assign v_sat   = alkd_pkg::sat32(vprod_q >>> 16);
	assign dprod   = $signed({1'b0, dt_q}) * v_sat;
	assign q_sum   = 64'(pos_rd) + (dprod_q >>> 16);

	always_comb begin
		pos_we    = 1'b0;
		pos_re    = 1'b0;
		mom_we    = 1'b0;
		mom_re    = 1'b0;
		pos_waddr = idx_w;
		pos_raddr = idx_a;
		mom_waddr = idx_w;
		mom_raddr = idx_a;
		pos_wdata = pin_q;
		mom_wdata = min_q;
		case (cmd.op)
			alkd_pkg::OP_WRITE: begin
				pos_we = addr_ok;
				mom_we = addr_ok;
			end
			alkd_pkg::OP_RD_ISSUE: begin
				pos_re    = 1'b1;
				mom_re    = 1'b1;
				pos_raddr = idx_w;
				mom_raddr = idx_w;
			end
			alkd_pkg::OP_K_RA: pos_re = 1'b1;
			alkd_pkg::OP_K_RB: begin
				pos_re    = 1'b1;
				pos_raddr = idx_b;
			end
			alkd_pkg::OP_U_M1: mom_re = 1'b1;
			alkd_pkg::OP_U_M2: begin
				mom_re    = 1'b1;
				mom_raddr = idx_b;
			end
			alkd_pkg::OP_U_M3: begin
				mom_we    = 1'b1;
				mom_waddr = idx_a;
				mom_wdata = alkd_pkg::sat32(pa_sum);
			end
			alkd_pkg::OP_U_M4: begin
				mom_we    = 1'b1;
				mom_waddr = idx_b;
				mom_wdata = alkd_pkg::sat32(pb_dif);
			end
			alkd_pkg::OP_D_RD: begin
				pos_re    = 1'b1;
				mom_re    = 1'b1;
				pos_raddr = entry_q;
				mom_raddr = entry_q;
			end
			alkd_pkg::OP_D_WR: begin
				pos_we    = 1'b1;
				pos_waddr = entry_q;
				pos_wdata = alkd_pkg::sat32(q_sum);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q    <= 31'd65536;
			spring_q <= 32'sd65536;
			quad_q   <= '0;
			cubic_q  <= '0;
			dt_q     <= 31'd655;
			sat_q    <= 1'b0;
			entry_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (alkd_pkg::cfg_reg_t'(cfg_index))
					alkd_pkg::CFG_INV_MASS:  inv_q    <= cfg_data[30:0];
					alkd_pkg::CFG_SPRING_K:  spring_q <= cfg_data;
					alkd_pkg::CFG_QUAD:      quad_q   <= cfg_data;
					alkd_pkg::CFG_CUBIC:     cubic_q  <= cfg_data;
					alkd_pkg::CFG_TIME_STEP: dt_q     <= cfg_data[30:0];
					default: begin
					end
				endcase
			end
			if (load) begin
				sat_q   <= 1'b0;
				entry_q <= '0;
			end else begin
				case (cmd.op)
					alkd_pkg::OP_K_DIFF: sat_q <= sat_q | d_ovf;
					alkd_pkg::OP_C_MUL:  sat_q <= sat_q | r2_ovf;
					alkd_pkg::OP_C_SUM:  sat_q <= sat_q | alkd_pkg::ovf32(64'(csum));
					alkd_pkg::OP_U_M2:   sat_q <= sat_q | alkd_pkg::ovf32(fprod_q >>> 16);
					alkd_pkg::OP_U_M3:   sat_q <= sat_q | alkd_pkg::ovf32(pa_sum);
					alkd_pkg::OP_U_M4:   sat_q <= sat_q | alkd_pkg::ovf32(pb_dif);
					alkd_pkg::OP_D_M2:   sat_q <= sat_q | alkd_pkg::ovf32(vprod_q >>> 16);
					alkd_pkg::OP_D_WR: begin
						sat_q   <= sat_q | alkd_pkg::ovf32(q_sum);
						entry_q <= entry_q + 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mode_q    <= alkd_pkg::mode_t'(mode);
			a_q       <= particle_a;
			b_q       <= particle_b;
			comp_q    <= component;
			pin_q     <= position_in;
			min_q     <= momentum_in;
			s_q       <= '0;
			pos_out_q <= '0;
			mom_out_q <= '0;
		end else begin
			case (cmd.op)
				alkd_pkg::OP_RD_TAKE: begin
					if (addr_ok) begin
						pos_out_q <= pos_rd;
						mom_out_q <= mom_rd;
					end
				end
				alkd_pkg::OP_K_RB:   qa_q <= pos_rd;
				alkd_pkg::OP_K_DIFF: d_q[c_idx] <= d_clip;
				alkd_pkg::OP_K_SQ:   sq_q <= sq_prod;
				alkd_pkg::OP_K_ACC:  s_q <= s_q + sq_q;
				alkd_pkg::OP_SQ_INIT: begin
					sh_q   <= s_q;
					rem_q  <= '0;
					root_q <= '0;
				end
				alkd_pkg::OP_SQ_STEP: begin
					sh_q <= {sh_q[61:0], 2'b00};
					if (rem_sh >= trial) begin
						rem_q  <= 33'(rem_sh - trial);
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q  <= rem_sh[32:0];
						root_q <= {root_q[30:0], 1'b0};
					end
				end
				alkd_pkg::OP_C_MUL: begin
					p1_q <= p1_full[63:0];
					p2_q <= p2_full;
				end
				alkd_pkg::OP_C_SUM: coeff_q <= alkd_pkg::sat32(64'(csum));
				alkd_pkg::OP_U_M1:  fprod_q <= fprod;
				alkd_pkg::OP_U_M2: begin
					iprod_q <= iprod;
					pa_q    <= mom_rd;
				end
				alkd_pkg::OP_D_M1: vprod_q <= vprod;
				alkd_pkg::OP_D_M2: dprod_q <= dprod;
				default: begin
				end
			endcase
		end
	end

	assign position_out = pos_out_q;
	assign momentum_out = mom_out_q;
	assign saturated    = sat_q;

	alkd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.re    (pos_re),
		.raddr (pos_raddr),
		.rdata (pos_rd)
	);

	alkd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mom_ram (
		.clk   (clk),
		.we    (mom_we),
		.waddr (mom_waddr),
		.wdata (mom_wdata),
		.re    (mom_re),
		.raddr (mom_raddr),
		.rdata (mom_rd)
	);

endmodule
`default_nettype wire

### sv/anharmonic_lattice_kick_drift.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anharmonic_lattice_kick_drift: fixed-point anharmonic lattice integrator
// Holds Q16.16 positions and momenta of a particle lattice; writes, reads,
// kicks one bond or drifts all particles per command, with saturation flag.
// ----------------------------------------------------------------------------
// One command at a time: a beat is taken when start is high and busy low, and
// its single result appears on the result ports with done high for one cycle.
// The receiver cannot stall, so sample the result in the done cycle. A kick
// reads both ends of each bond component in turn, takes a 32-step square root
// at one root bit per cycle, then updates both momenta of each component; a
// drift steps every stored entry through read, two multiply steps and write
// back. A kick with an end out of range or both ends equal finishes with no
// change. Configuration beats are taken only while idle and no command is
// offered.
// ----------------------------------------------------------------------------
module anharmonic_lattice_kick_drift #(
	parameter int MAX_PARTICLES = 256,
	parameter int DIMS          = 3
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     mode,
	input  wire logic [7:0]                     particle_a,
	input  wire logic [7:0]                     particle_b,
	input  wire logic [1:0]                     component,
	input  wire logic signed [31:0]             position_in,
	input  wire logic signed [31:0]             momentum_in,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [alkd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data,
	output logic                                done,
	output logic signed [31:0]                  position_out,
	output logic signed [31:0]                  momentum_out,
	output logic                                saturated
);

	alkd_pkg::dp_cmd_t  cmd;
	alkd_pkg::dp_stat_t stat;
	logic               load;

	assign cfg_ready = !busy && !start;

	alkd_ctrl #(.DIMS(DIMS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.load   (load),
		.cmd    (cmd),
		.done   (done)
	);

	alkd_dp #(.MAX_PARTICLES(MAX_PARTICLES), .DIMS(DIMS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (mode),
		.particle_a   (particle_a),
		.particle_b   (particle_b),
		.component    (component),
		.position_in  (position_in),
		.momentum_in  (momentum_in),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.position_out (position_out),
		.momentum_out (momentum_out),
		.saturated    (saturated)
	);

endmodule
`default_nettype wire

### sim/anharmonic_lattice_kick_drift_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anharmonic_lattice_kick_drift_tb: self-checking bench of the lattice engine
// Fills every store entry, walks a directed table of commands, then sends
// random writes, kicks, drifts and reads under several register settings.
// Every done beat is compared with a table value or a bit-exact model of the Q16.16 update.
// ----------------------------------------------------------------------------
module anharmonic_lattice_kick_drift_tb;

	localparam int NPART   = 256;
	localparam int NDIM    = 3;
	localparam int NENTRY  = NPART * NDIM;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] pos;
		logic signed [31:0] mom;
		logic               sat;
	} lat_res_t;

	typedef struct {
		alkd_pkg::mode_t    md;
		logic [7:0]         pa;
		logic [7:0]         pb;
		logic [1:0]         comp;
		logic signed [31:0] pin;
		logic signed [31:0] min;
		bit                 typed;
		lat_res_t           res;
	} lat_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] mode = '0;
	logic [7:0] particle_a = '0;
	logic [7:0] particle_b = '0;
	logic [1:0] component = '0;
	logic signed [31:0] position_in = '0;
	logic signed [31:0] momentum_in = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [alkd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic done;
	logic signed [31:0] position_out;
	logic signed [31:0] momentum_out;
	logic saturated;

	anharmonic_lattice_kick_drift #(.MAX_PARTICLES(NPART), .DIMS(NDIM)) dut (.*);

	always #5 clk = ~clk;

	logic signed [31:0] pos_mem [NENTRY];
	logic signed [31:0] mom_mem [NENTRY];
	longint m_inv, m_k, m_alpha, m_beta, m_dt;
	lat_res_t pending_res[$];
	int errors = 0;
	bit idle_on = 1'b1;

	function automatic longint clamp(longint x, longint lo, longint hi, ref bit f);
		if (x > hi) begin
			f = 1'b1;
			return hi;
		end
		if (x < lo) begin
			f = 1'b1;
			return lo;
		end
		return x;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned rem, root, b;
		rem = x;
		root = 0;
		b = 64'd1 << 62;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	task automatic lattice_step(alkd_pkg::mode_t md, int a, int b, int c,
			logic signed [31:0] pin, logic signed [31:0] min, output lat_res_t r);
		bit f;
		longint d [NDIM];
		longint unsigned s;
		longint rt, r2, coeff, frc, imp, v, dq;
		f = 1'b0;
		r.pos = '0;
		r.mom = '0;
		case (md)
			alkd_pkg::MODE_WRITE: begin
				if (c < NDIM) begin
					pos_mem[a*NDIM+c] = pin;
					mom_mem[a*NDIM+c] = min;
				end
			end
			alkd_pkg::MODE_KICK: begin
				if (a != b) begin
					s = 0;
					for (int i = 0; i < NDIM; i++) begin
						d[i] = clamp(longint'(pos_mem[b*NDIM+i]) - longint'(pos_mem[a*NDIM+i]),
							-QMAX, QMAX, f);
						s = s + longint'(d[i] * d[i]);
					end
					rt = longint'(int_sqrt(s));
					r2 = clamp(longint'(s >> 16), 0, QMAX, f);
					coeff = clamp(m_k + ((m_alpha * rt) >>> 16) + ((m_beta * r2) >>> 16),
						QMIN, QMAX, f);
					for (int i = 0; i < NDIM; i++) begin
						frc = clamp((coeff * d[i]) >>> 16, QMIN, QMAX, f);
						imp = (m_dt * frc) >>> 16;
						mom_mem[a*NDIM+i] = clamp(longint'(mom_mem[a*NDIM+i]) + imp, QMIN, QMAX, f);
						mom_mem[b*NDIM+i] = clamp(longint'(mom_mem[b*NDIM+i]) - imp, QMIN, QMAX, f);
					end
				end
			end
			alkd_pkg::MODE_DRIFT: begin
				for (int i = 0; i < NENTRY; i++) begin
					v = clamp((longint'(mom_mem[i]) * m_inv) >>> 16, QMIN, QMAX, f);
					dq = (m_dt * v) >>> 16;
					pos_mem[i] = clamp(longint'(pos_mem[i]) + dq, QMIN, QMAX, f);
				end
			end
			default: begin
				if (c < NDIM) begin
					r.pos = pos_mem[a*NDIM+c];
					r.mom = mom_mem[a*NDIM+c];
				end
			end
		endcase
		r.sat = f;
	endtask

	task automatic report(string what);
		$display("MISMATCH %s at %0t", what, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		lat_res_t e;
		if (arst_n && done) begin
			if (pending_res.size() == 0) begin
				report("unexpected result beat");
			end else begin
				e = pending_res.pop_front();
				if (position_out !== e.pos)
					report($sformatf("position_out %h exp %h", position_out, e.pos));
				if (momentum_out !== e.mom)
					report($sformatf("momentum_out %h exp %h", momentum_out, e.mom));
				if (saturated !== e.sat)
					report($sformatf("saturated %b exp %b", saturated, e.sat));
			end
		end
	end

	task automatic send_cmd(alkd_pkg::mode_t md, logic [7:0] a, logic [7:0] b,
			logic [1:0] c, logic signed [31:0] pin, logic signed [31:0] min, bit typed,
			lat_res_t tres);
		lat_res_t r;
		if (idle_on && $urandom_range(99) < 22) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 22);
		end
		start <= 1'b1;
		mode <= md;
		particle_a <= a;
		particle_b <= b;
		component <= c;
		position_in <= pin;
		momentum_in <= min;
		do @(posedge clk); while (busy);
		lattice_step(md, a, b, c, pin, min, r);
		pending_res.push_back(typed ? tres : r);
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_res.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_reg(alkd_pkg::cfg_reg_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			alkd_pkg::CFG_INV_MASS:  m_inv = longint'(val & 32'h7fffffff);
			alkd_pkg::CFG_SPRING_K:  m_k = longint'(signed'(val));
			alkd_pkg::CFG_QUAD:      m_alpha = longint'(signed'(val));
			alkd_pkg::CFG_CUBIC:     m_beta = longint'(signed'(val));
			default:                 m_dt = longint'(val & 32'h7fffffff);
		endcase
	endtask

	task automatic load_regs(logic [31:0] im, logic [31:0] k, logic [31:0] al,
			logic [31:0] be, logic [31:0] dt);
		drain();
		write_reg(alkd_pkg::CFG_INV_MASS, im);
		write_reg(alkd_pkg::CFG_SPRING_K, k);
		write_reg(alkd_pkg::CFG_QUAD, al);
		write_reg(alkd_pkg::CFG_CUBIC, be);
		write_reg(alkd_pkg::CFG_TIME_STEP, dt);
	endtask

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return $urandom;
			default: return $signed($urandom_range(262143)) - 32'sd131072;
		endcase
	endfunction

	initial begin
		lat_row_t rows[$];
		lat_res_t zr;
		alkd_pkg::mode_t md;
		logic [7:0] a;
		zr = '{pos: '0, mom: '0, sat: 1'b0};
		m_inv = 65536;
		m_k = 65536;
		m_alpha = 0;
		m_beta = 0;
		m_dt = 655;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NENTRY; i++)
			send_cmd(alkd_pkg::MODE_WRITE, i / NDIM, $urandom, i % NDIM, rand_q(), rand_q(),
				1'b1, zr);

		rows.push_back('{alkd_pkg::MODE_WRITE, 8'd0, 8'd0, 2'd0, 32'sh7fffffff,
			32'sh80000000, 1, zr});
		rows.push_back('{alkd_pkg::MODE_READ, 8'd0, 8'd255, 2'd0, 0, 0, 1,
			'{32'sh7fffffff, 32'sh80000000, 1'b0}});
		rows.push_back('{alkd_pkg::MODE_WRITE, 8'd255, 8'd0, 2'd2, 32'sh80000000,
			32'sh7fffffff, 1, zr});
		rows.push_back('{alkd_pkg::MODE_READ, 8'd255, 8'd0, 2'd2, 0, 0, 1,
			'{32'sh80000000, 32'sh7fffffff, 1'b0}});
		rows.push_back('{alkd_pkg::MODE_WRITE, 8'd7, 8'd0, 2'd3, 32'sh12345678,
			32'sh9abcdef0, 1, zr});
		rows.push_back('{alkd_pkg::MODE_READ, 8'd7, 8'd0, 2'd3, 0, 0, 1, zr});
		rows.push_back('{alkd_pkg::MODE_KICK, 8'd5, 8'd5, 2'd0, 0, 0, 1, zr});
		rows.push_back('{alkd_pkg::MODE_KICK, 8'd0, 8'd255, 2'd1, 0, 0, 0, zr});
		rows.push_back('{alkd_pkg::MODE_KICK, 8'd1, 8'd2, 2'd0, 0, 0, 0, zr});
		rows.push_back('{alkd_pkg::MODE_KICK, 8'd255, 8'd254, 2'd0, 0, 0, 0, zr});
		rows.push_back('{alkd_pkg::MODE_DRIFT, 8'd0, 8'd0, 2'd0, 0, 0, 0, zr});
		rows.push_back('{alkd_pkg::MODE_READ, 8'd0, 8'd0, 2'd0, 0, 0, 0, zr});
		rows.push_back('{alkd_pkg::MODE_READ, 8'd255, 8'd0, 2'd2, 0, 0, 0, zr});
		rows.push_back('{alkd_pkg::MODE_READ, 8'd1, 8'd0, 2'd1, 0, 0, 0, zr});
		foreach (rows[i])
			send_cmd(rows[i].md, rows[i].pa, rows[i].pb, rows[i].comp, rows[i].pin,
				rows[i].min, rows[i].typed, rows[i].res);

		for (int n = 0; n < 420; n++) begin
			case (n)
				60: load_regs(32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
					32'h7fffffff);
				120: load_regs(32'h0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0);
				180: load_regs($urandom, $urandom, $urandom, $urandom, $urandom);
				260: load_regs($urandom_range(131072), $signed($urandom_range(131072)) - 65536,
					$signed($urandom_range(8192)) - 4096, $signed($urandom_range(256)) - 128,
					$urandom_range(2000));
				340: load_regs(32'd65536, 32'd65536, 32'd0, 32'd0, 32'd655);
				default: ;
			endcase
			if (n == 200) drain();
			idle_on = !(n >= 205 && n < 300);
			case ($urandom_range(99)) inside
				[0:29]:  md = alkd_pkg::MODE_WRITE;
				[30:64]: md = alkd_pkg::MODE_KICK;
				[65:67]: md = alkd_pkg::MODE_DRIFT;
				default: md = alkd_pkg::MODE_READ;
			endcase
			a = $urandom;
			send_cmd(md, a, ($urandom_range(9) == 0) ? a : 8'($urandom), $urandom_range(3),
				rand_q(), rand_q(), 1'b0, zr);
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_res.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#50000000;
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
